>>> rtl/core/sql_like_wildcard_matcher_macros.svh
// assertion helpers for the matcher checker
`ifndef SQL_LIKE_WILDCARD_MATCHER_MACROS_SVH
`define SQL_LIKE_WILDCARD_MATCHER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/slw_pkg.sv
package slw_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] char_value;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } out_item_t;

    // wildcard bytes
    localparam logic [7:0] CH_ANY_RUN = 8'h25;
    localparam logic [7:0] CH_ANY_ONE = 8'h5F;

endpackage

>>> rtl/core/sql_like_wildcard_matcher.sv
// SQL LIKE matcher. Load a pattern with append transfers ('%' any run, '_' any
// single byte, every other byte itself, case-sensitive), then stream text bytes,
// one per transfer, and close each text with an end-of-text transfer; only that
// transfer yields a result: matched plus the pattern overflow flag. A clear
// transfer empties the pattern and the overflow flag. Appends past PATTERN_MAX
// bytes are dropped and set the overflow flag; an append in the middle of a
// text restarts matching with the next text byte. Throughput is one transfer per
// cycle; an end-of-text result passes the input register, then the result register.
// The cycle time is set by the live-position update: per-position byte
// compares followed by a log-depth prefix network that carries live positions
// across runs of '%'. item_ready only drops while an end-of-text transfer waits
// behind a result that the consumer has not taken.
module sql_like_wildcard_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  slw_pkg::in_item_t item,
    output logic              result_valid,
    input  logic              result_ready,
    output slw_pkg::out_item_t result
);
    import slw_pkg::*;

    localparam int N     = PATTERN_MAX;
    localparam int W     = N + 1;
    localparam int LEN_W = $clog2(W);
    localparam int AW    = (N > 1) ? $clog2(N) : 1;

    // input register stage
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;

    // result register stage
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    // pattern state; the byte store has no reset, only bytes below the length are read
    logic [7:0]       store_reg [N];
    logic [LEN_W-1:0] len_reg, len_next;
    logic [N-1:0]     pct_reg, pct_next;   // '%' at a stored position
    logic             overflow_reg, overflow_next;
    logic [W-1:0]     live_reg, live_next;

    logic         proc_fire;
    logic         out_free;
    logic         room;
    logic         is_append;
    logic         is_clear;
    logic [W-1:0] step_vec;
    logic [W-1:0] seed;
    logic [W-1:0] closed;

    assign out_free   = !out_valid_reg || result_ready;
    assign proc_fire  = in_valid_reg && ((in_item_reg.cmd != CMD_END) || out_free);
    assign item_ready = !in_valid_reg || proc_fire;

    assign room      = (len_reg < LEN_W'(N));
    assign is_append = proc_fire && (in_item_reg.cmd == CMD_APPEND);
    assign is_clear  = proc_fire && (in_item_reg.cmd == CMD_CLEAR);

    // one text byte moves every live position in parallel
    always_comb
    begin
        step_vec = '0;
        for (int i = 0; i < N; i++)
        begin
            if (live_reg[i])
            begin
                if (pct_reg[i])
                begin
                    step_vec[i] = 1'b1;
                end
                else if ((LEN_W'(i) < len_reg) &&
                         ((store_reg[i] == CH_ANY_ONE) ||
                          (store_reg[i] == in_item_reg.char_value)))
                begin
                    step_vec[i+1] = 1'b1;
                end
            end
        end
    end

    // '%' map after this transfer; rearm and step both close over it
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (is_clear)
            begin
                pct_next[i] = 1'b0;
            end
            else if (is_append && room && (len_reg == LEN_W'(i)))
            begin
                pct_next[i] = (in_item_reg.char_value == CH_ANY_RUN);
            end
            else
            begin
                pct_next[i] = pct_reg[i];
            end
        end
    end

    assign seed = (in_item_reg.cmd == CMD_TEXT) ? step_vec : W'(1);

    slw_closure #(
        .N (N)
    ) u_closure (
        .seed   (seed),
        .pct    (pct_next),
        .closed (closed)
    );

    // state update for the transfer in the input register
    always_comb
    begin
        len_next      = len_reg;
        overflow_next = overflow_reg;
        live_next     = live_reg;
        if (proc_fire)
        begin
            live_next = closed;
            case (in_item_reg.cmd)
                CMD_CLEAR:
                begin
                    len_next      = '0;
                    overflow_next = 1'b0;
                end
                CMD_APPEND:
                begin
                    if (room)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                CMD_TEXT:
                begin
                    len_next = len_reg;
                end
                CMD_END:
                begin
                    len_next = len_reg;
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    // handshake stages
    always_comb
    begin
        if (item_valid && item_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (proc_fire && (in_item_reg.cmd == CMD_END))
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            pct_reg       <= '0;
            overflow_reg  <= 1'b0;
            live_reg      <= W'(1);   // empty pattern: only position zero live
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            pct_reg       <= pct_next;
            overflow_reg  <= overflow_next;
            live_reg      <= live_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
        if (proc_fire && (in_item_reg.cmd == CMD_END))
        begin
            out_item_reg.matched          <= live_reg[len_reg];
            out_item_reg.pattern_overflow <= overflow_reg;
        end
        if (is_append && room)
        begin
            store_reg[len_reg[AW-1:0]] <= in_item_reg.char_value;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

>>> rtl/core/slw_closure.sv
module slw_closure #(
    parameter int N = 32
) (
    input  logic [N:0]   seed,
    input  logic [N-1:0] pct,
    output logic [N:0]   closed
);
    localparam int W      = N + 1;
    localparam int LEVELS = $clog2(W);

    // parallel prefix: a live bit moves up one position across each '%'
    logic [LEVELS:0][W-1:0] g_lvl;
    logic [LEVELS:0][W-1:0] p_lvl;

    assign g_lvl[0] = seed;
    assign p_lvl[0] = {pct, 1'b0};

    for (genvar k = 0; k < LEVELS; k++) begin : g_level
        localparam int D = 1 << k;
        for (genvar j = 0; j < W; j++) begin : g_bit
            if (j >= D) begin : g_comb
                assign g_lvl[k+1][j] = g_lvl[k][j] | (p_lvl[k][j] & g_lvl[k][j-D]);
                assign p_lvl[k+1][j] = p_lvl[k][j] & p_lvl[k][j-D];
            end
            else begin : g_pass
                assign g_lvl[k+1][j] = g_lvl[k][j];
                assign p_lvl[k+1][j] = p_lvl[k][j];
            end
        end
    end

    assign closed = g_lvl[LEVELS];

endmodule

>>> rtl/core/slw_checker.sv
`include "sql_like_wildcard_matcher_macros.svh"

module slw_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input slw_pkg::in_item_t  item,
    input logic               result_valid,
    input logic               result_ready,
    input slw_pkg::out_item_t result
);
    import slw_pkg::*;

    // a stalled result holds
    `SLW_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result), "result changed while stalled")

    // input back-pressure only comes from a stalled result
    `SLW_ASSERT_NOW(a_ready_cause, !item_ready,
        result_valid && !result_ready, "input stalled without a stalled result")

    // a fresh result follows an end-of-text transfer
    `SLW_ASSERT_NOW(a_result_source, $rose(result_valid),
        $past(item_valid && item_ready && (item.cmd == CMD_END), 2),
        "result without an end-of-text transfer")

endmodule

bind sql_like_wildcard_matcher slw_checker u_slw_checker (.*);

>>> bench/sql_like_wildcard_matcher_tb.sv
`timescale 1ns / 1ps

module sql_like_wildcard_matcher_tb;

    import slw_pkg::*;

    localparam int PATTERN_MAX  = 32;
    localparam int ITEM_TARGET  = 1400;
    // a result passes the input and result registers after its end-of-text transfer
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD    = 300;

    // tracks the matcher state and the verdicts still owed by the block
    class like_match_predictor;
        logic [7:0]           pattern_bytes [PATTERN_MAX];
        int unsigned          pattern_len;
        logic [PATTERN_MAX:0] live;
        bit                   overflowed;
        out_item_t            expected_verdicts [$];
        int unsigned          verdict_errors;

        function new();
            foreach (pattern_bytes[i])
                pattern_bytes[i] = '0;
            pattern_len    = 0;
            overflowed     = 1'b0;
            verdict_errors = 0;
            rearm();
        endfunction

        // a live position sitting on '%' also makes the next one live
        function logic [PATTERN_MAX:0] close_over_any_run(input logic [PATTERN_MAX:0] v);
            for (int i = 0; i < pattern_len; i++)
                if (v[i] && pattern_bytes[i] == CH_ANY_RUN)
                    v[i + 1] = 1'b1;
            return v;
        endfunction

        function void rearm();
            logic [PATTERN_MAX:0] start;
            start    = '0;
            start[0] = 1'b1;
            live = close_over_any_run(start);
        endfunction

        function void note_transfer(input in_item_t t);
            logic [PATTERN_MAX:0] nxt;
            out_item_t            verdict;
            case (t.cmd)
                CMD_CLEAR:
                begin
                    pattern_len = 0;
                    overflowed  = 1'b0;
                    rearm();
                end
                CMD_APPEND:
                begin
                    if (pattern_len < PATTERN_MAX)
                    begin
                        pattern_bytes[pattern_len] = t.char_value;
                        pattern_len++;
                    end
                    else
                    begin
                        overflowed = 1'b1;
                    end
                    rearm();
                end
                CMD_TEXT:
                begin
                    nxt = '0;
                    for (int i = 0; i < pattern_len; i++)
                    begin
                        if (live[i])
                        begin
                            if (pattern_bytes[i] == CH_ANY_RUN)
                                nxt[i] = 1'b1;
                            else if (pattern_bytes[i] == CH_ANY_ONE ||
                                     pattern_bytes[i] == t.char_value)
                                nxt[i + 1] = 1'b1;
                        end
                    end
                    live = close_over_any_run(nxt);
                end
                default:
                begin
                    verdict.matched          = live[pattern_len];
                    verdict.pattern_overflow = overflowed;
                    expected_verdicts = {expected_verdicts, verdict};
                    rearm();
                end
            endcase
        endfunction

        function void check_verdict(input out_item_t got);
            out_item_t want;
            if (expected_verdicts.size() == 0)
            begin
                $error("result transfer with no end of text pending");
                verdict_errors++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.matched !== want.matched)
            begin
                $error("matched: expected %0b, got %0b", want.matched, got.matched);
                verdict_errors++;
            end
            if (got.pattern_overflow !== want.pattern_overflow)
            begin
                $error("pattern_overflow: expected %0b, got %0b",
                       want.pattern_overflow, got.pattern_overflow);
                verdict_errors++;
            end
        endfunction

        function int pending_count();
            return expected_verdicts.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    logic      result_valid;
    logic      result_ready;
    out_item_t result;

    like_match_predictor predictor = new();

    // stimulus side mirror of what the pattern store holds, used to build texts
    logic [7:0]  loaded_pattern [$];
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    // zero-gap stretches on either side
    bit          sender_eager = 1'b0;
    bit          receiver_eager = 1'b0;
    // raised by the stimulus, taken down by the receiver once it starts the hold
    bit          long_hold_request = 1'b0;
    bit          flood_done = 1'b0;

    sql_like_wildcard_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // sample both channels at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                predictor.note_transfer(item);
            if (result_valid && result_ready)
                predictor.check_verdict(result);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random hold-off per transfer, or one long hold on request
    initial
    begin
        int pause;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            pause = receiver_eager ? 0 : $urandom_range(0, 12);
            if (long_hold_request)
            begin
                pause             = LONG_HOLD;
                long_hold_request = 1'b0;
            end
            if (pause > 0)
            begin
                result_ready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
            @(negedge clk);
        end
    end

    // text bytes lean on letters, wildcard bytes and the byte extremes
    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 7))
            0:       return "a";
            1:       return "b";
            2:       return "A";
            3:       return CH_ANY_RUN;
            4:       return CH_ANY_ONE;
            5:       return 8'h00;
            6:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // pattern bytes carry more wildcards than texts do
    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(0, 9))
            0, 1:    return CH_ANY_RUN;
            2, 3:    return CH_ANY_ONE;
            4:       return "a";
            5:       return "b";
            6:       return "A";
            7:       return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly short patterns, some mid-size, a few near or past the store size
    function automatic int draw_pattern_length();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $urandom_range(0, 6);
        else if (pick < 9)
            return $urandom_range(7, 20);
        else
            return $urandom_range(PATTERN_MAX - 2, PATTERN_MAX + 8);
    endfunction

    // one input transfer; valid stays up until taken, then an idle gap may follow
    task automatic send_item(input cmd_t op, input logic [7:0] byte_value);
        int gap;
        item_valid <= 1'b1;
        item       <= '{cmd: op, char_value: byte_value};
        do @(posedge clk); while (item_ready !== 1'b1);
        items_sent++;
        case (op)
            CMD_CLEAR:  loaded_pattern.delete();
            CMD_APPEND:
            begin
                if (loaded_pattern.size() < PATTERN_MAX)
                    loaded_pattern = {loaded_pattern, byte_value};
            end
            default:    ;
        endcase
        @(negedge clk);
        gap = sender_eager ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // sender stops offering until every owed verdict has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        do @(negedge clk); while (predictor.pending_count() != 0);
    endtask

    task automatic load_pattern(input int len);
        send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
        repeat (len) send_item(CMD_APPEND, pick_pattern_byte());
    endtask

    // build a text that fits the loaded pattern; a spoiled one drops or
    // replaces positions and may trail extra bytes
    task automatic send_text_against_pattern(input bit spoil);
        logic [7:0] snapshot [$];
        int         run_len;
        snapshot = loaded_pattern;
        foreach (snapshot[i])
        begin
            if (spoil && $urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 1))
                    send_item(CMD_TEXT, pick_text_byte());
                continue;
            end
            if (snapshot[i] == CH_ANY_RUN)
            begin
                run_len = $urandom_range(0, 3);
                repeat (run_len) send_item(CMD_TEXT, pick_text_byte());
            end
            else if (snapshot[i] == CH_ANY_ONE)
            begin
                send_item(CMD_TEXT, pick_text_byte());
            end
            else
            begin
                send_item(CMD_TEXT, snapshot[i]);
            end
        end
        if (spoil && $urandom_range(0, 1))
            repeat ($urandom_range(1, 4)) send_item(CMD_TEXT, pick_text_byte());
        send_item(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_query();
        load_pattern(draw_pattern_length());
        repeat ($urandom_range(1, 3))
            send_text_against_pattern($urandom_range(0, 2) == 0);
    endtask

    // arbitrary commands and bytes: appends mid-text, stray ends and clears
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // receiver goes quiet while back-to-back texts keep coming, so an end-of-text
    // transfer waits behind an untaken result and the input stalls
    task automatic flood_output();
        long_hold_request = 1'b1;
        sender_eager      = 1'b1;
        load_pattern(2);
        repeat (16) send_text_against_pattern(1'b0);
        wait_drained();
    endtask

    task automatic run_directed();
        // reset state: empty pattern against the empty text
        send_item(CMD_END, 8'h00);
        // clear ignores its byte
        send_item(CMD_CLEAR, 8'hFF);
        // lone percent takes the empty text and a text holding a percent alike
        send_item(CMD_APPEND, CH_ANY_RUN);
        send_item(CMD_END, 8'hFF);
        send_item(CMD_TEXT, CH_ANY_RUN);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_END, 8'h00);
        // literals compare case-sensitively
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_APPEND, "A");
        send_item(CMD_TEXT, "a");
        send_item(CMD_END, 8'h00);
        // text longer than any match leaves nothing live
        send_item(CMD_TEXT, "A");
        send_item(CMD_TEXT, "A");
        send_item(CMD_END, 8'h00);
        // underscore eats one byte, extreme bytes stored as literals
        send_item(CMD_APPEND, CH_ANY_ONE);
        send_item(CMD_APPEND, 8'hFF);
        send_item(CMD_TEXT, "A");
        send_item(CMD_TEXT, 8'h00);
        // append in the middle of a text restarts the match
        send_item(CMD_APPEND, CH_ANY_RUN);
        send_item(CMD_TEXT, "A");
        send_item(CMD_TEXT, CH_ANY_RUN);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_END, 8'hFF);
        // text underscore is only a byte against a literal
        send_item(CMD_TEXT, CH_ANY_ONE);
        send_item(CMD_END, 8'h00);
    endtask

    // main stimulus
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        while (items_sent < ITEM_TARGET)
        begin
            sender_eager   = ($urandom_range(0, 4) == 0);
            receiver_eager = ($urandom_range(0, 4) == 0);
            if (!flood_done && items_sent >= ITEM_TARGET / 2)
            begin
                flood_output();
                flood_done = 1'b1;
            end
            else if ($urandom_range(0, 9) < 8)
            begin
                run_query();
            end
            else
            begin
                send_noise();
            end
            // occasional full drain so the block also restarts from idle
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (predictor.verdict_errors == 0 && predictor.pending_count() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
